// ===== rtl/core/ordered_list_with_delete_unit_macros.svh =====
// Assertion macros for the ordered list unit.
// Stand-alone header; no dependencies.
`ifndef ORDERED_LIST_WITH_DELETE_UNIT_MACROS_SVH
`define ORDERED_LIST_WITH_DELETE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset.
`define OLWD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked out of reset.
`define OLWD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define OLWD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define OLWD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== rtl/core/olwd_pkg.sv =====
// Shared types and constants for the ordered list unit.
// No dependencies.
package olwd_pkg;

  localparam int unsigned DefaultCapacity = 16;

  typedef enum logic [2:0] {
    FUNC_APPEND    = 3'd0,
    FUNC_DEL_FIRST = 3'd1,
    FUNC_DEL_LAST  = 3'd2,
    FUNC_DEL_VALUE = 3'd3,
    FUNC_READ_ALL  = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] entry_value;
    logic               last;
    logic [4:0]         entry_count;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FINISH_DEL,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_RD_REQ,
    S_RD_SEND
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic    load_req;
    logic    idx_clr;
    logic    idx_inc;
    logic    rd_cur;
    logic    rd_next;
    logic    wr_tail;
    logic    wr_shift;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    out_load;
    status_e out_status;
    logic    out_entry;
    logic    out_last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] func;
    logic       cnt_zero;
    logic       cnt_full;
    logic       match;
    logic       idx_last;
    logic       out_free;
  } sts_t;

endpackage

// ===== rtl/core/olwd_ctrl.sv =====
// Sequencer for the ordered list unit: decodes requests and steps the
// datapath through scans, shifts and read-outs. Depends on olwd_pkg.
module olwd_ctrl import olwd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (sts_i.func)
          FUNC_DEL_FIRST: begin
            if (!sts_i.cnt_zero) state_d = S_SHIFT_RD;
            else if (sts_i.out_free) state_d = S_IDLE;
          end
          FUNC_DEL_VALUE: begin
            if (!sts_i.cnt_zero) state_d = S_SCAN_RD;
            else if (sts_i.out_free) state_d = S_IDLE;
          end
          FUNC_READ_ALL: begin
            if (!sts_i.cnt_zero) state_d = S_RD_REQ;
            else if (sts_i.out_free) state_d = S_IDLE;
          end
          default: begin
            if (sts_i.out_free) state_d = S_IDLE;
          end
        endcase
      end
      S_SHIFT_RD: state_d = sts_i.idx_last ? S_FINISH_DEL : S_SHIFT_WR;
      S_SHIFT_WR: state_d = S_SHIFT_RD;
      S_FINISH_DEL: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      S_SCAN_RD: state_d = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (sts_i.match) state_d = S_SHIFT_RD;
        else if (!sts_i.idx_last) state_d = S_SCAN_RD;
        else if (sts_i.out_free) state_d = S_IDLE;
      end
      S_RD_REQ: state_d = S_RD_SEND;
      S_RD_SEND: begin
        if (sts_i.out_free) state_d = sts_i.idx_last ? S_IDLE : S_RD_REQ;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o            = '0;
    cmd_o.out_status = ST_OK;
    cmd_o.out_last   = 1'b1;
    in_ready_o       = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.load_req = in_valid_i;
      end
      S_DISPATCH: begin
        case (sts_i.func)
          FUNC_APPEND: begin
            if (sts_i.out_free) begin
              cmd_o.out_load = 1'b1;
              if (sts_i.cnt_full) begin
                cmd_o.out_status = ST_FULL;
              end else begin
                cmd_o.wr_tail = 1'b1;
                cmd_o.cnt_inc = 1'b1;
              end
            end
          end
          FUNC_DEL_LAST: begin
            if (sts_i.out_free) begin
              cmd_o.out_load = 1'b1;
              if (sts_i.cnt_zero) cmd_o.out_status = ST_EMPTY;
              else cmd_o.cnt_dec = 1'b1;
            end
          end
          FUNC_DEL_FIRST, FUNC_DEL_VALUE, FUNC_READ_ALL: begin
            if (!sts_i.cnt_zero) begin
              cmd_o.idx_clr = 1'b1;
            end else if (sts_i.out_free) begin
              cmd_o.out_load   = 1'b1;
              cmd_o.out_status = ST_EMPTY;
            end
          end
          default: begin
            cmd_o.out_load = sts_i.out_free;
          end
        endcase
      end
      S_SHIFT_RD: cmd_o.rd_next = !sts_i.idx_last;
      S_SHIFT_WR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.idx_inc  = 1'b1;
      end
      S_FINISH_DEL: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.cnt_dec  = 1'b1;
        end
      end
      S_SCAN_RD: cmd_o.rd_cur = 1'b1;
      S_SCAN_CMP: begin
        if (!sts_i.match) begin
          if (!sts_i.idx_last) begin
            cmd_o.idx_inc = 1'b1;
          end else if (sts_i.out_free) begin
            cmd_o.out_load   = 1'b1;
            cmd_o.out_status = ST_NOTFOUND;
          end
        end
      end
      S_RD_REQ: cmd_o.rd_cur = 1'b1;
      S_RD_SEND: begin
        if (sts_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_entry = 1'b1;
          cmd_o.out_last  = sts_i.idx_last;
          cmd_o.idx_inc   = !sts_i.idx_last;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/olwd_dp.sv =====
// Datapath of the ordered list unit: entry memory, count, walk index,
// request latch and result register. Depends on olwd_pkg.
module olwd_dp import olwd_pkg::*; #(
  parameter int unsigned CAPACITY = DefaultCapacity
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t in_word_i,
  output rsp_t out_word_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  cmd_t cmd_i,
  output sts_t sts_o
);

  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);

  logic signed [31:0] mem [CAPACITY];
  logic signed [31:0] rd_q;
  req_t               req_q;
  rsp_t               out_q;
  logic               out_vld_q, out_vld_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [CntW-1:0]    idx_q, idx_d;
  logic [CntW-1:0]    idx_nxt;
  logic [CntW+4:0]    cnt_ext;
  logic [AddrW-1:0]   rd_addr, wr_addr;
  logic signed [31:0] wr_data;
  logic               wr_en;

  assign idx_nxt = idx_q + 1'b1;
  assign cnt_ext = {5'b0, count_d};

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) count_d = count_q + 1'b1;
    else if (cmd_i.cnt_dec) count_d = count_q - 1'b1;
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_clr) idx_d = '0;
    else if (cmd_i.idx_inc) idx_d = idx_nxt;
  end

  // Read the current cell for scans and read-outs, the next one for shifts
  assign rd_addr = cmd_i.rd_next ? idx_nxt[AddrW-1:0] : idx_q[AddrW-1:0];
  assign wr_addr = cmd_i.wr_tail ? count_q[AddrW-1:0] : idx_q[AddrW-1:0];
  assign wr_data = cmd_i.wr_tail ? req_q.value : rd_q;
  assign wr_en   = cmd_i.wr_tail || cmd_i.wr_shift;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd_i.rd_cur || cmd_i.rd_next) rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q <= in_word_i;
    if (cmd_i.out_load) begin
      out_q.status      <= cmd_i.out_status;
      out_q.entry_value <= cmd_i.out_entry ? rd_q : 32'sd0;
      out_q.last        <= cmd_i.out_last;
      out_q.entry_count <= cnt_ext[4:0];
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_i.out_load) out_vld_d = 1'b1;
    else if (out_ready_i) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign sts_o.func     = req_q.func;
  assign sts_o.cnt_zero = (count_q == '0);
  assign sts_o.cnt_full = (count_q == CntW'(CAPACITY));
  assign sts_o.match    = (rd_q == req_q.value);
  assign sts_o.idx_last = (idx_nxt == count_q);
  assign sts_o.out_free = !out_vld_q || out_ready_i;

  assign out_word_o  = out_q;
  assign out_valid_o = out_vld_q;

endmodule

// ===== rtl/core/ordered_list_with_delete_unit.sv =====
// Ordered list unit: bounded list of signed 32-bit values with append,
// delete first/last/by value and read-all. Uses olwd_pkg, olwd_ctrl, olwd_dp.
//
// A request word (func, value) enters on in_valid_i/in_ready_o; result words
// (status, entry_value, last, entry_count) leave on out_valid_o/out_ready_i.
// Requests are handled one at a time: in_ready_o is high only while the
// sequencer is idle. The entries sit in a single-port-write, single-read
// memory with a registered read, so each cell of a walk is read in one state
// and then shifted, compared or sent in a second. Append, delete last and
// unused codes finish in the dispatch state, as does any request on an empty
// list. Delete first shifts every later entry down one place; delete value
// scans for the first match and then shifts; read all returns count words,
// one per entry, with last set on the final one. The next request is taken
// the cycle after the last word is loaded. A result register parts the
// output: a new request can be accepted while the previous word waits, and
// the sequencer holds whenever it has a word to give and that register is
// still occupied with out_ready_i low. Reset empties the list and drops any
// pending word; memory contents are not cleared.
`include "ordered_list_with_delete_unit_macros.svh"
module ordered_list_with_delete_unit import olwd_pkg::*; #(
  parameter int unsigned CAPACITY = DefaultCapacity
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_word_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_word_o
);

  cmd_t cmd;
  sts_t sts;

  olwd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  olwd_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .out_word_o  (out_word_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  `OLWD_ASSERT_NOW(a_full_at_capacity, clk_i, rst_ni,
    out_valid_o && (out_word_o.status == ST_FULL),
    out_word_o.entry_count == 5'(CAPACITY), "full status below capacity")
  `OLWD_ASSERT_NOW(a_status_word_alone, clk_i, rst_ni,
    out_valid_o && (out_word_o.status != ST_OK),
    out_word_o.last && (out_word_o.entry_value == 32'sd0), "bad error word")
  `OLWD_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni,
    in_valid_i && in_ready_o, !in_ready_o, "request taken while busy")

endmodule

// ===== test/ordered_list_with_delete_unit_test.sv =====
// Self-checking bench for ordered_list_with_delete_unit: directed corner cases, then
// random request streams scored against a queue-based model of the list.
// Depends on olwd_pkg and the unit itself.
module ordered_list_with_delete_unit_test;
  import olwd_pkg::*;

  localparam int unsigned Capacity   = DefaultCapacity;
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned TailCycles = 40;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_word;

  // model of the list contents and the result words still owed by the unit
  logic signed [31:0] list_model[$];
  rsp_t               owed_rsps[$];

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned stall_left = 0;
  bit          send_gaps = 1'b1;
  bit          sink_stalls = 1'b1;

  ordered_list_with_delete_unit #(.CAPACITY(Capacity)) dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o (out_word)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d words still owed", $time, owed_rsps.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: random back-pressure in bursts
  always @(posedge clk) begin
    if (!sink_stalls) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 12) - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
  endtask

  always @(posedge clk) begin : score_words
    rsp_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (owed_rsps.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual %0h", $time, out_word);
      end else begin
        want = owed_rsps.pop_front();
        if (out_word.status !== want.status)
          report_field("status", want.status, out_word.status);
        if (out_word.entry_value !== want.entry_value)
          report_field("entry_value", want.entry_value, out_word.entry_value);
        if (out_word.last !== want.last)
          report_field("last", want.last, out_word.last);
        if (out_word.entry_count !== want.entry_count)
          report_field("entry_count", want.entry_count, out_word.entry_count);
      end
    end
  end

  // Apply one request to the list model and queue the words it owes.
  task automatic apply_list_op(input req_t w);
    rsp_t r;
    int   hit;
    hit = -1;
    r = '0;
    r.last = 1'b1;
    r.status = ST_OK;
    case (w.func)
      FUNC_APPEND: begin
        if (list_model.size() >= Capacity) r.status = ST_FULL;
        else list_model.push_back(w.value);
      end
      FUNC_DEL_FIRST: begin
        if (list_model.size() == 0) r.status = ST_EMPTY;
        else void'(list_model.pop_front());
      end
      FUNC_DEL_LAST: begin
        if (list_model.size() == 0) r.status = ST_EMPTY;
        else void'(list_model.pop_back());
      end
      FUNC_DEL_VALUE: begin
        if (list_model.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          foreach (list_model[i])
            if (hit < 0 && list_model[i] == w.value) hit = i;
          if (hit >= 0) list_model.delete(hit);
          else r.status = ST_NOTFOUND;
        end
      end
      FUNC_READ_ALL: begin
        if (list_model.size() == 0) r.status = ST_EMPTY;
      end
      default: ;
    endcase
    r.entry_count = 5'(list_model.size());
    if (w.func == FUNC_READ_ALL && list_model.size() != 0) begin
      foreach (list_model[i]) begin
        r.entry_value = list_model[i];
        r.last = (i == list_model.size() - 1);
        owed_rsps.push_back(r);
      end
    end else begin
      owed_rsps.push_back(r);
    end
  endtask

  // Offer one request word; valid stays up across back-to-back words.
  task automatic send_word(input logic [2:0] func, input logic signed [31:0] value);
    req_t w;
    w.func = func;
    w.value = value;
    if (send_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    apply_list_op(w);
  endtask

  // Hold the sender until every owed word has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (owed_rsps.size() != 0);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      5, 6:    pick_value = $signed($urandom_range(0, 6)) - 3;
      7:       pick_value = 32'sh8000_0000;
      8:       pick_value = 32'sh7fff_ffff;
      9:       pick_value = (list_model.size() != 0) ?
                 list_model[$urandom_range(0, list_model.size() - 1)] : $urandom();
      default: pick_value = $urandom();
    endcase
  endfunction

  task automatic test_empty_list();
    send_word(FUNC_DEL_FIRST, 32'sd0);
    send_word(FUNC_DEL_LAST, 32'sd0);
    send_word(FUNC_DEL_VALUE, 32'sh7fff_ffff);
    send_word(FUNC_READ_ALL, 32'sd0);
    send_word(3'd7, 32'shffff_ffff);
  endtask

  task automatic test_single_entry();
    send_word(FUNC_APPEND, 32'sh8000_0000);
    send_word(FUNC_DEL_LAST, 32'sd0);
  endtask

  task automatic test_fill_to_full();
    logic signed [31:0] fill[16];
    fill = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sd0, -32'sd1, 32'sh5555_5555,
             32'shaaaa_aaaa, 32'sd1, 32'sd0, -32'sd1, 32'sh0000_ffff,
             32'shffff_0000, 32'sh1234_5678, 32'sd0, 32'sh7fff_fffe,
             32'sh8000_0001, 32'sd42};
    foreach (fill[i]) send_word(FUNC_APPEND, fill[i]);
    send_word(FUNC_APPEND, 32'sd5);
    send_word(FUNC_READ_ALL, 32'sd0);
    // a duplicated value: only the first copy goes
    send_word(FUNC_DEL_VALUE, 32'sd0);
    send_word(FUNC_DEL_VALUE, 32'sd99);
    send_word(FUNC_DEL_FIRST, 32'sd0);
    send_word(FUNC_READ_ALL, 32'sd0);
  endtask

  task automatic test_random_streams(input int unsigned n_items);
    int unsigned pick;
    int unsigned append_cut;
    logic signed [31:0] v;
    for (int unsigned n = 0; n < n_items; n++) begin
      if (n == n_items / 2) wait_drained();
      if (n == n_items - 60) begin
        send_gaps = 1'b0;
        sink_stalls = 1'b0;
      end
      // alternate growing and shrinking stretches so the list hits both ends
      append_cut = ((n / 40) % 2 == 0) ? 55 : 20;
      if ($urandom_range(0, 99) < append_cut) begin
        send_word(FUNC_APPEND, pick_value());
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
          send_word(FUNC_DEL_FIRST, $urandom());
        end else if (pick < 44) begin
          send_word(FUNC_DEL_LAST, $urandom());
        end else if (pick < 74) begin
          if (list_model.size() != 0 && $urandom_range(0, 9) < 7)
            v = list_model[$urandom_range(0, list_model.size() - 1)];
          else
            v = pick_value();
          send_word(FUNC_DEL_VALUE, v);
        end else if (pick < 93) begin
          send_word(FUNC_READ_ALL, $urandom());
        end else begin
          send_word(3'($urandom_range(5, 7)), $urandom());
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_single_entry();
    test_fill_to_full();
    test_random_streams(350);
    in_valid <= 1'b0;
    do @(posedge clk); while (owed_rsps.size() != 0);
    repeat (TailCycles) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
